// File: design/btfs_pkg.sv
// Shared types and constants for the Bezier transfer-function sampler.
// No dependencies.
`default_nettype none
package btfs_pkg;

  localparam int FracBits = 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TPOW,
    ST_UPOW,
    ST_WEIGHT,
    ST_WSCALE,
    ST_ACC,
    ST_CXMUL,
    ST_VMUL,
    ST_FINISH,
    ST_OUT
  } btfs_state_t;

  typedef struct packed {
    logic start;
    logic init_pow;
    logic tpow_step;
    logic upow_step;
    logic weight_step;
    logic wscale_step;
    logic acc_step;
    logic cx_step;
    logic val_step;
    logic finish;
  } btfs_cmd_t;

  // Binomial coefficient for small n, k (n <= 15), picked from Pascal's triangle.
  // The rows are constant, so only the final selection depends on n and k.
  function automatic logic [13:0] choose(input logic [3:0] n, input logic [3:0] k);
    logic [13:0] row [16];
    logic [13:0] res;
    for (int j = 0; j < 16; j++) row[j] = (j == 0) ? 14'd1 : 14'd0;
    res = 14'd0;
    for (int r = 0; r < 16; r++) begin
      if (r > 0) begin
        for (int j = 15; j > 0; j--) row[j] = row[j] + row[j-1];
      end
      if (4'(r) == n) res = row[k];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: design/btfs_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
`default_nettype none
module btfs_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/btfs_datapath.sv
// Datapath: control-point store, power tables, shared multiplier and accumulators.
// Depends on btfs_pkg and btfs_ram.
`default_nettype none
module btfs_datapath #(
  parameter int MaxPoints    = 8,
  parameter int TableEntries = 1024
) (
  input  wire logic                       clk,
  input  wire btfs_pkg::btfs_cmd_t        cmd,
  input  wire logic [$clog2(MaxPoints)-1:0] step_idx,
  input  wire logic [$clog2(MaxPoints)-1:0] deg,
  input  wire logic                       load_we,
  input  wire logic [2:0]                 load_idx,
  input  wire logic [31:0]                load_data,
  input  wire logic [16:0]                t_in,
  input  wire logic [1:0]                 channel,
  input  wire logic [15:0]                height,
  input  wire logic [31:0]                inv_scale_x,
  input  wire logic [31:0]                inv_scale_y,
  output logic [15:0]                     curve_x,
  output logic [15:0]                     curve_y,
  output logic [9:0]                      table_index,
  output logic [16:0]                     table_value,
  output logic                            in_range
);
  import btfs_pkg::*;

  localparam int IW = $clog2(MaxPoints);
  localparam int SlotW = 52;

  logic [31:0] ram_rdata;
  logic        ram_we;
  logic [IW-1:0] ram_waddr;

  // Load indices beyond storage are dropped.
  assign ram_we    = load_we && (int'(load_idx) < MaxPoints);
  assign ram_waddr = IW'(load_idx);

  btfs_ram #(.Width(32), .Depth(MaxPoints)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(load_data),
    .raddr(step_idx),
    .rdata(ram_rdata)
  );

  logic [30:0] t30, u30;
  logic [30:0] tp [MaxPoints];
  logic [30:0] up [MaxPoints];
  logic [30:0] mul_a, mul_b;
  logic [61:0] prod;
  logic [30:0] wbase;
  logic [44:0] weight;
  logic signed [63:0] sx, sy;
  logic signed [33:0] cxs, cys;
  logic signed [63:0] colprod, valprod;
  logic [IW-1:0] nmi;

  assign nmi = deg - step_idx;

  // One shared 31x31 multiplier for the power and weight steps.
  always_comb begin
    unique if (cmd.tpow_step) begin
      mul_a = tp[step_idx - IW'(1)];
      mul_b = t30;
    end else if (cmd.upow_step) begin
      mul_a = up[step_idx - IW'(1)];
      mul_b = u30;
    end else begin
      mul_a = tp[step_idx];
      mul_b = up[nmi];
    end
  end

  assign prod = 62'(mul_a) * 62'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      logic [16:0] tc;
      tc = (t_in > 17'd65536) ? 17'd65536 : t_in;
      t30 <= {tc, 14'd0};
      u30 <= {17'd65536 - tc, 14'd0};
      sx <= '0;
      sy <= '0;
    end
    if (cmd.init_pow) begin
      tp[0] <= 31'h4000_0000;
      up[0] <= 31'h4000_0000;
    end
    if (cmd.tpow_step)
      tp[step_idx] <= prod[60:30];
    if (cmd.upow_step)
      up[step_idx] <= prod[60:30];
    if (cmd.weight_step)
      wbase <= prod[60:30];
    if (cmd.wscale_step)
      weight <= 45'(wbase) * 45'(choose(4'(deg), 4'(step_idx)));
    if (cmd.acc_step) begin
      sx <= sx + 64'($signed(weight) * 64'($signed(ram_rdata[15:0])));
      sy <= sy + 64'($signed(weight) * 64'($signed(ram_rdata[31:16])));
    end
    if (cmd.cx_step) begin
      // Truncate toward zero on division by 2^30.
      logic signed [63:0] ax, ay;
      ax = sx + ((sx < 0) ? 64'sd1073741823 : 64'sd0);
      ay = sy + ((sy < 0) ? 64'sd1073741823 : 64'sd0);
      cxs <= 34'(ax >>> 30);
      cys <= 34'(ay >>> 30);
    end
    if (cmd.val_step) begin
      colprod <= 64'($signed(cxs)) * $signed({32'd0, inv_scale_x});
      valprod <= (64'sd0 + $signed({48'd0, height}) - 64'($signed(cys)))
                 * $signed({32'd0, inv_scale_y});
    end
    if (cmd.finish) begin
      logic signed [63:0] col, slot;
      logic ok;
      col  = (colprod + ((colprod < 0) ? 64'sd65535 : 64'sd0)) >>> 16;
      slot = (col <<< 2) + 64'($signed({1'b0, channel}));
      ok   = (slot >= 0) && (slot < 64'(TableEntries));
      curve_x     <= cxs[15:0];
      curve_y     <= cys[15:0];
      in_range    <= ok;
      table_index <= ok ? slot[9:0] : 10'd0;
      table_value <= !ok ? 17'd0 :
                     (valprod < 0) ? 17'd0 :
                     (valprod > 64'sd65536) ? 17'd65536 : valprod[16:0];
    end
  end
endmodule
`default_nettype wire

// File: design/btfs_ctrl.sv
// Controller: sequences power, weight and accumulate steps per evaluation.
// Depends on btfs_pkg.
`default_nettype none
module btfs_ctrl #(
  parameter int MaxPoints = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_fire,
  input  wire logic                        in_eval,
  input  wire logic [2:0]                  degree,
  input  wire logic                        out_fire,
  output logic                             busy,
  output logic                             out_valid,
  output btfs_pkg::btfs_cmd_t              cmd,
  output logic [$clog2(MaxPoints)-1:0]     step_idx,
  output logic [$clog2(MaxPoints)-1:0]     deg
);
  import btfs_pkg::*;
  localparam int IW = $clog2(MaxPoints);

  btfs_state_t state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] n, n_next;
  logic [3:0]    deg_sat;

  assign deg_sat = ({1'b0, degree} > 4'(MaxPoints - 1)) ? 4'(MaxPoints - 1) : {1'b0, degree};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      n     <= n_next;
    end
  end

  assign step_idx  = idx;
  assign deg       = n;
  assign busy      = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    n_next     = n;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && in_eval) begin
          cmd.start = 1'b1;
          n_next    = IW'(deg_sat);
          idx_next  = '0;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.init_pow = 1'b1;
        idx_next = IW'(1);
        state_next = (n == '0) ? ST_WEIGHT : ST_TPOW;
        if (n == '0) idx_next = '0;
      end
      ST_TPOW: begin
        cmd.tpow_step = 1'b1;
        state_next = ST_UPOW;
      end
      ST_UPOW: begin
        cmd.upow_step = 1'b1;
        if (idx == n) begin
          idx_next = '0;
          state_next = ST_WEIGHT;
        end else begin
          idx_next = idx + IW'(1);
          state_next = ST_TPOW;
        end
      end
      ST_WEIGHT: begin
        cmd.weight_step = 1'b1;
        state_next = ST_WSCALE;
      end
      ST_WSCALE: begin
        cmd.wscale_step = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (idx == n) begin
          state_next = ST_CXMUL;
        end else begin
          idx_next = idx + IW'(1);
          state_next = ST_WEIGHT;
        end
      end
      ST_CXMUL: begin
        cmd.cx_step = 1'b1;
        state_next = ST_VMUL;
      end
      ST_VMUL: begin
        cmd.val_step = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: design/bezier_transfer_function_sampler.sv
// Bezier transfer-function sampler.
// Input channel s_axis: tuser = operation (0 load point, 1 evaluate), tdata carries
// point_index, point_x, point_y and t_param. A load writes one control point and
// gives no result; an evaluation gives one result on m_axis.
// Configuration channel cfg: index 0 degree, 1 channel, 2 height, 3 inv_scale_x,
// 4 inv_scale_y; writes beyond the list are ignored.
// For degree n, m_axis_tvalid rises after the input transfer, once the controller has passed
// a set-up state, the power steps (t and 1-t in turn), weight, scale and accumulate
// steps for each of the n+1 terms through one shared multiplier reading the control-point RAM,
// and the final scaling states (column multiply, value multiply, finish). The next item
// is taken only after the result of an evaluation has been taken. A load is taken when idle.
// One item is in work at a time; s_axis_tready is low until the result is taken.
// If the receiver stalls, the result holds on m_axis and the block waits.
// Synchronous reset returns the registers to their defaults (degree 3, channel 0,
// height 256, inv_scale_x 65536, inv_scale_y 256); control points stay unknown
// until loaded.
// Depends on btfs_pkg, btfs_ram, btfs_datapath and btfs_ctrl.
`default_nettype none
module bezier_transfer_function_sampler #(
  parameter int MAX_POINTS    = 8,
  parameter int TABLE_ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // point_index[2:0], point_x, point_y, t_param, pad
  input  wire logic        s_axis_tuser,  // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // curve_x, curve_y, table_index, table_value, in_range
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import btfs_pkg::*;

  localparam logic [2:0] RegDegree = 3'd0;
  localparam logic [2:0] RegChannel = 3'd1;
  localparam logic [2:0] RegHeight = 3'd2;
  localparam logic [2:0] RegInvX = 3'd3;
  localparam logic [2:0] RegInvY = 3'd4;
  localparam int IW = $clog2(MAX_POINTS);

  logic [2:0]  degree;
  logic [1:0]  channel;
  logic [15:0] height;
  logic [31:0] inv_scale_x, inv_scale_y;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= 3'd3; channel <= 2'd0; height <= 16'd256;
      inv_scale_x <= 32'd65536; inv_scale_y <= 32'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegDegree:  degree <= cfg_data[2:0];
        RegChannel: channel <= cfg_data[1:0];
        RegHeight:  height <= cfg_data[15:0];
        RegInvX:    inv_scale_x <= cfg_data;
        RegInvY:    inv_scale_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic busy, in_fire, out_fire;
  btfs_cmd_t cmd;
  logic [IW-1:0] step_idx, deg;
  logic [15:0] curve_x, curve_y;
  logic [9:0]  table_index;
  logic [16:0] table_value;
  logic        in_range;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  btfs_ctrl #(.MaxPoints(MAX_POINTS)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_eval(s_axis_tuser),
    .degree(degree), .out_fire(out_fire), .busy(busy), .out_valid(m_axis_tvalid),
    .cmd(cmd), .step_idx(step_idx), .deg(deg)
  );

  btfs_datapath #(.MaxPoints(MAX_POINTS), .TableEntries(TABLE_ENTRIES)) u_dp (
    .clk(clk), .cmd(cmd), .step_idx(step_idx), .deg(deg),
    .load_we(in_fire && !s_axis_tuser), .load_idx(s_axis_tdata[2:0]),
    .load_data(s_axis_tdata[34:3]), .t_in(s_axis_tdata[51:35]),
    .channel(channel), .height(height), .inv_scale_x(inv_scale_x),
    .inv_scale_y(inv_scale_y), .curve_x(curve_x), .curve_y(curve_y),
    .table_index(table_index), .table_value(table_value), .in_range(in_range)
  );

  assign m_axis_tdata = {4'd0, in_range, table_value, table_index, curve_y, curve_x};
endmodule
`default_nettype wire
